[design/ctsm_pkg.sv]
// ----------------------------------------------------------------------------
// Core-to-core sharing monitor package
// Shared field widths, action codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctsm_pkg;

  // Field widths fixed by the event format.
  localparam int ACTION_W    = 2;
  localparam int CPU_W       = 3;
  localparam int ADDR_W      = 64;
  localparam int BLOCK_SHIFT = 6;
  localparam int TAG_W       = ADDR_W - BLOCK_SHIFT;
  localparam int LEN_W       = 31;
  localparam int CNT_W32     = 32;

  // Interval length after reset.
  localparam logic [LEN_W-1:0] DEFAULT_INTERVAL = 31'd10000000;

  // Event action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_RETIRE = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_COMPARE,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // capture the incoming event, clear the flags
    logic retire;      // count a core 0 retirement
    logic scan_start;  // begin the table walk at entry zero
    logic advance;     // step to the next table entry
    logic match_upd;   // update the entry that matched
    logic miss_upd;    // no entry matched: allocate on a store
    logic load_out;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_retire;   // latched event is a core 0 retirement
    logic is_mem;      // latched event is a tracked load or store
    logic tbl_empty;   // no entry allocated yet
    logic tag_match;   // entry just read matches the block
    logic last_entry;  // entry just read is the last allocated one
    logic out_free;    // output register can take a result
  } status_t;

endpackage

[design/ctsm_if.sv]
// ----------------------------------------------------------------------------
// Core-to-core sharing monitor channels
// Valid/ready channels for the event input, the result output and the
// interval length configuration write.
// ----------------------------------------------------------------------------

// Event input channel.
interface ctsm_in_if;
  import ctsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACTION_W-1:0] action;
  logic [CPU_W-1:0]  cpu;
  logic [ADDR_W-1:0] phys_addr;
  logic              is_io;

  modport source (output valid, action, cpu, phys_addr, is_io, input ready);
  modport sink   (input valid, action, cpu, phys_addr, is_io, output ready);
endinterface

// Result output channel.
interface ctsm_out_if;
  import ctsm_pkg::*;
  logic               valid;
  logic               ready;
  logic               interval_end;
  logic [CNT_W32-1:0] interval_count;
  logic [CNT_W32-1:0] interval_number;
  logic               entry_hit;
  logic               transfer_seen;
  logic               table_full;

  modport source (output valid, interval_end, interval_count, interval_number,
                  entry_hit, transfer_seen, table_full, input ready);
  modport sink   (input valid, interval_end, interval_count, interval_number,
                  entry_hit, transfer_seen, table_full, output ready);
endinterface

// Configuration write channel.
interface ctsm_cfg_if;
  import ctsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] retire_period;

  modport source (output valid, retire_period, input ready);
  modport sink   (input valid, retire_period, output ready);
endinterface

[design/ctsm_ctrl.sv]
// ----------------------------------------------------------------------------
// Core-to-core sharing monitor controller
// Sequences one event at a time: capture, dispatch, table walk with one
// memory read per entry, and hand-off to the output register.
// ----------------------------------------------------------------------------
module ctsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctsm_pkg::status_t sts,
  output ctsm_pkg::cmd_t    cmd
);
  import ctsm_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.is_mem && !sts.tbl_empty) state_nxt = S_READ;
        else                              state_nxt = S_RESULT;
      end
      S_READ: begin
        state_nxt = S_COMPARE;
      end
      S_COMPARE: begin
        if (sts.tag_match || sts.last_entry) state_nxt = S_RESULT;
        else                                 state_nxt = S_READ;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands. No transaction is taken while reset is held.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = rst_n;
        cmd.accept = in_valid && rst_n;
      end
      S_DISPATCH: begin
        cmd.retire     = sts.is_retire;
        cmd.scan_start = sts.is_mem && !sts.tbl_empty;
        cmd.miss_upd   = sts.is_mem && sts.tbl_empty;
      end
      S_READ: begin
      end
      S_COMPARE: begin
        cmd.match_upd = sts.tag_match;
        cmd.miss_upd  = !sts.tag_match && sts.last_entry;
        cmd.advance   = !sts.tag_match && !sts.last_entry;
      end
      S_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A new event is taken only once the previous result has been handed off.
  a_accept_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> ($past(state_r) == S_RESULT || $past(state_r) == S_IDLE))
    else $error("event accepted during processing");

  // Every compare follows a memory read cycle.
  a_compare_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPARE) |-> ($past(state_r) == S_READ))
    else $error("compare without a preceding read");

  // Table updates are mutually exclusive with walking on.
  a_one_walk_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.match_upd, cmd.miss_upd, cmd.advance, cmd.scan_start}) <= 1)
    else $error("conflicting table commands");
`endif

endmodule

[design/ctsm_dp.sv]
// ----------------------------------------------------------------------------
// Core-to-core sharing monitor datapath
// Holds the event being processed, the block table memory, the allocation
// count, the retire and transfer counters and the output register.
// ----------------------------------------------------------------------------
module ctsm_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int NUM_CORES     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctsm_pkg::cmd_t                cmd,
  output ctsm_pkg::status_t             sts,
  input  logic [ctsm_pkg::ACTION_W-1:0] in_action,
  input  logic [ctsm_pkg::CPU_W-1:0]    in_cpu,
  input  logic [ctsm_pkg::ADDR_W-1:0]   in_phys_addr,
  input  logic                          in_is_io,
  input  logic                          cfg_we,
  input  logic [ctsm_pkg::LEN_W-1:0]    cfg_retire_period,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_interval_end,
  output logic [ctsm_pkg::CNT_W32-1:0]  out_interval_count,
  output logic [ctsm_pkg::CNT_W32-1:0]  out_interval_number,
  output logic                          out_entry_hit,
  output logic                          out_transfer_seen,
  output logic                          out_table_full
);
  import ctsm_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = TAG_W + NUM_CORES;

  // Latched event.
  logic [ACTION_W-1:0] action_r;
  logic [CPU_W-1:0]    cpu_r;
  logic [TAG_W-1:0]    tag_r;
  logic                io_r;

  // Table memory: block tag over sharer mask.
  logic [WORD_W-1:0]   mem [TABLE_ENTRIES];
  logic [WORD_W-1:0]   rd_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  // Walk and allocation state.
  logic [FILL_W-1:0]   scan_idx_r;
  logic [FILL_W-1:0]   next_free_r;
  logic [FILL_W-1:0]   scan_inc;

  // Counters and configuration.
  logic [CNT_W32-1:0]  xfer_cnt_r;
  logic [CNT_W32-1:0]  retire_cnt_r;
  logic [CNT_W32-1:0]  interval_id_r;
  logic [LEN_W-1:0]    len_r;
  logic [CNT_W32-1:0]  retire_sum;
  logic                retire_ends;

  // Result flags of the current event and the output register.
  logic                end_r, hit_r, xfer_r, full_r;
  logic [CNT_W32-1:0]  count_r;
  logic                out_valid_r;

  logic                cpu_ok;
  logic [NUM_CORES-1:0] cpu_bit;
  logic [TAG_W-1:0]    rd_tag;
  logic [NUM_CORES-1:0] rd_sh;
  logic                tbl_has_room;
  logic                new_sharer;

  // Event decode.
  always_comb begin
    cpu_ok = 32'(cpu_r) < 32'(NUM_CORES);
    for (int i = 0; i < NUM_CORES; i++) begin
      cpu_bit[i] = (32'(cpu_r) == 32'(i));
    end
  end

  assign rd_tag       = rd_q[WORD_W-1:NUM_CORES];
  assign rd_sh        = rd_q[NUM_CORES-1:0];
  assign scan_inc     = scan_idx_r + FILL_W'(1);
  assign tbl_has_room = next_free_r < FILL_W'(TABLE_ENTRIES);
  assign new_sharer   = (rd_sh & cpu_bit) == '0;
  assign retire_sum   = retire_cnt_r + CNT_W32'(1);
  assign retire_ends  = retire_sum >= {1'b0, len_r};

  // Status to the controller.
  always_comb begin
    sts.is_retire  = (action_r == ACT_RETIRE) && (cpu_r == '0);
    sts.is_mem     = ((action_r == ACT_LOAD) || (action_r == ACT_STORE)) && !io_r && cpu_ok;
    sts.tbl_empty  = next_free_r == '0;
    sts.tag_match  = rd_tag == tag_r;
    sts.last_entry = scan_inc == next_free_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Table write port: update of the matched entry or allocation of a new one.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_idx_r[IDX_W-1:0];
    mem_wdata = {tag_r, cpu_bit};
    if (cmd.match_upd) begin
      if (action_r == ACT_STORE) begin
        mem_we = 1'b1;
      end else if (new_sharer) begin
        mem_we    = 1'b1;
        mem_wdata = {tag_r, rd_sh | cpu_bit};
      end
    end else if (cmd.miss_upd && (action_r == ACT_STORE) && tbl_has_room) begin
      mem_we    = 1'b1;
      mem_waddr = next_free_r[IDX_W-1:0];
    end
  end

  // Table memory with registered read at the walk index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[scan_idx_r[IDX_W-1:0]];
  end

  // Event capture and walk index.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      cpu_r    <= in_cpu;
      tag_r    <= in_phys_addr[ADDR_W-1:BLOCK_SHIFT];
      io_r     <= in_is_io;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.advance) begin
      scan_idx_r <= scan_inc;
    end
  end

  // Per-event result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r   <= 1'b0;
      count_r <= '0;
      hit_r   <= 1'b0;
      xfer_r  <= 1'b0;
      full_r  <= 1'b0;
    end else if (cmd.accept) begin
      end_r   <= 1'b0;
      count_r <= '0;
      hit_r   <= 1'b0;
      xfer_r  <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      if (cmd.retire && retire_ends) begin
        end_r   <= 1'b1;
        count_r <= xfer_cnt_r;
      end
      if (cmd.match_upd) begin
        hit_r <= 1'b1;
        if ((action_r == ACT_LOAD) && new_sharer) xfer_r <= 1'b1;
      end
      if (cmd.miss_upd && (action_r == ACT_STORE) && !tbl_has_room) begin
        full_r <= 1'b1;
      end
    end
  end

  // Allocation count, counters and interval length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r   <= '0;
      xfer_cnt_r    <= '0;
      retire_cnt_r  <= '0;
      interval_id_r <= '0;
      len_r         <= DEFAULT_INTERVAL;
    end else begin
      if (cfg_we) len_r <= cfg_retire_period;
      if (cmd.miss_upd && (action_r == ACT_STORE) && tbl_has_room) begin
        next_free_r <= next_free_r + FILL_W'(1);
      end
      if (cmd.retire) begin
        if (retire_ends) begin
          interval_id_r <= interval_id_r + CNT_W32'(1);
          xfer_cnt_r    <= '0;
          retire_cnt_r  <= '0;
        end else begin
          retire_cnt_r <= retire_sum;
        end
      end else if (cmd.match_upd && (action_r == ACT_LOAD) && new_sharer &&
                   (xfer_cnt_r != '1)) begin
        xfer_cnt_r <= xfer_cnt_r + CNT_W32'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_interval_end    <= end_r;
      out_interval_count  <= count_r;
      out_interval_number <= interval_id_r;
      out_entry_hit       <= hit_r;
      out_transfer_seen   <= xfer_r;
      out_table_full      <= full_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // The allocation count never runs past the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= FILL_W'(TABLE_ENTRIES))
    else $error("allocation count beyond table size");

  // A dropped store only happens with the table full.
  a_full_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (next_free_r == FILL_W'(TABLE_ENTRIES)))
    else $error("store dropped while entries are free");

  // A drop and a hit cannot come from the same event.
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (!hit_r && !xfer_r))
    else $error("dropped store also flagged as hit");

  // Closing an interval clears both counters.
  a_interval_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.retire && retire_ends) |=> (xfer_cnt_r == '0 && retire_cnt_r == '0))
    else $error("counters not cleared at interval end");
`endif

endmodule

[design/core_to_core_sharing_monitor_top.sv]
// ----------------------------------------------------------------------------
// Core-to-core sharing monitor
// Tracks which cores share each 64-byte block, counts core-to-core transfers
// and reports the count at the end of every core 0 retirement interval.
// ----------------------------------------------------------------------------
// Sequence: an accepted event is dispatched; a retirement or an ignored event
//   then goes to the result state, while a load or store first walks up to
//   TABLE_ENTRIES allocated entries, one read and one compare each, to a match
//   or the last (none if empty). The result waits for a free output register;
//   the next event is accepted the cycle after it moves into that register.
// Reset: synchronous, active low; the table is empty at once (fill count),
//   with no clearing pass, and the interval length returns to 10000000.
module core_to_core_sharing_monitor_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int NUM_CORES     = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  ctsm_in_if.sink    in_ch,
  ctsm_out_if.source out_ch,
  ctsm_cfg_if.sink   cfg_ch
);
  import ctsm_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  // Configuration writes are taken whenever reset is released.
  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = in_ready;

  // Event sequencing.
  ctsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, counters and output register.
  ctsm_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NUM_CORES     (NUM_CORES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_ch.action),
    .in_cpu              (in_ch.cpu),
    .in_phys_addr        (in_ch.phys_addr),
    .in_is_io            (in_ch.is_io),
    .cfg_we              (cfg_ch.valid),
    .cfg_retire_period   (cfg_ch.retire_period),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_interval_end    (out_ch.interval_end),
    .out_interval_count  (out_ch.interval_count),
    .out_interval_number (out_ch.interval_number),
    .out_entry_hit       (out_ch.entry_hit),
    .out_transfer_seen   (out_ch.transfer_seen),
    .out_table_full      (out_ch.table_full)
  );

endmodule

[tb/core_to_core_sharing_monitor_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core-to-core sharing monitor testbench
// Sends retire, load and store events through the valid/ready input channel
// and checks every result against a typed value or a predictor of the
// sharing table, the transfer count and the interval logic. A directed table
// runs first, then random traffic over a pool of blocks under several
// interval lengths, with random idling, long output stalls and full drains.
// ----------------------------------------------------------------------------
module core_to_core_sharing_monitor_top_test;
  import ctsm_pkg::*;

  localparam int TABLE_ENTRIES   = 64;
  localparam int NUM_CORES       = 8;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int POOL_BLOCKS     = 80;
  localparam int CYCLE_LIMIT     = 1500000;

  // One event as the input channel carries it.
  typedef struct packed {
    action_t            action;
    bit [CPU_W-1:0]     cpu;
    bit [ADDR_W-1:0]    addr;
    bit                 io;
  } share_ev_t;

  // One result as the output channel carries it.
  typedef struct packed {
    bit                 interval_end;
    bit [CNT_W32-1:0]   interval_count;
    bit [CNT_W32-1:0]   interval_number;
    bit                 entry_hit;
    bit                 transfer_seen;
    bit                 table_full;
  } share_res_t;

  // A row of the directed table: either a length write or an event.
  typedef struct {
    bit                 is_length;
    bit [LEN_W-1:0]     length;
    share_ev_t          ev;
    bit                 typed;
    share_res_t         want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ctsm_in_if  in_ch ();
  ctsm_out_if out_ch ();
  ctsm_cfg_if cfg_ch ();

  core_to_core_sharing_monitor_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .NUM_CORES    (NUM_CORES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predicted state of the sharing table and the interval counters.
  bit                 blk_valid   [TABLE_ENTRIES];
  bit [TAG_W-1:0]     blk_tag     [TABLE_ENTRIES];
  bit [CPU_W-1:0]     blk_writer  [TABLE_ENTRIES];
  bit [NUM_CORES-1:0] blk_sharers [TABLE_ENTRIES];
  int unsigned        blk_used;
  bit [CNT_W32-1:0]   xfer_total;
  bit [CNT_W32-1:0]   core0_retired;
  bit [CNT_W32-1:0]   interval_idx;
  bit [LEN_W-1:0]     ilen;

  share_res_t         due_results [$];
  dir_row_t           directed_rows [$];
  bit [TAG_W-1:0]     address_pool [POOL_BLOCKS];
  int unsigned        pool_size [NUM_PHASES] = '{6, 16, 30, 48, 64, 72, 80, 80};
  bit [LEN_W-1:0]     phase_len [NUM_PHASES] =
                        '{2, 5, 0, 1, 31'h7FFF_FFFF, 13, 7, 3};

  bit quiet;
  int n_sent, n_results, n_intervals, n_hits, n_xfers, n_full, n_lengths;
  int errors;
  int cycle_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one event to the predicted state and returns its result.
  function automatic share_res_t predict_sharing(share_ev_t ev);
    share_res_t         r;
    int                 slot;
    int                 i;
    bit [TAG_W-1:0]     blk;
    bit [NUM_CORES-1:0] core_bit;
    r = '0;
    slot = -1;
    blk = ev.addr[ADDR_W-1:BLOCK_SHIFT];
    core_bit = '0;
    core_bit[ev.cpu] = 1'b1;
    if (ev.cpu < NUM_CORES) begin
      if (ev.action == ACT_RETIRE) begin
        // Only core 0 retirements advance the interval.
        if (ev.cpu == 0) begin
          core0_retired++;
          if (core0_retired >= {1'b0, ilen}) begin
            interval_idx++;
            r.interval_end = 1'b1;
            r.interval_count = xfer_total;
            xfer_total = '0;
            core0_retired = '0;
          end
        end
      end else if ((ev.action == ACT_LOAD || ev.action == ACT_STORE) && !ev.io) begin
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot < 0 && blk_valid[i] && blk_tag[i] == blk) slot = i;
        end
        if (slot >= 0) begin
          r.entry_hit = 1'b1;
          if (ev.action == ACT_STORE) begin
            blk_writer[slot] = ev.cpu;
            blk_sharers[slot] = core_bit;
          end else if ((blk_sharers[slot] & core_bit) == '0) begin
            blk_sharers[slot] |= core_bit;
            if (xfer_total != '1) xfer_total++;
            r.transfer_seen = 1'b1;
          end
        end else if (ev.action == ACT_STORE) begin
          // A store to a new block takes the next entry, or is dropped.
          if (blk_used < TABLE_ENTRIES) begin
            blk_valid[blk_used] = 1'b1;
            blk_tag[blk_used] = blk;
            blk_writer[blk_used] = ev.cpu;
            blk_sharers[blk_used] = core_bit;
            blk_used++;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
    end
    r.interval_number = interval_idx;
    return r;
  endfunction

  function automatic void add_event(action_t act, bit [CPU_W-1:0] cpu,
                                    bit [ADDR_W-1:0] addr, bit io, bit typed = 1'b0,
                                    bit want_end = 1'b0, bit [CNT_W32-1:0] want_count = '0,
                                    bit [CNT_W32-1:0] want_number = '0,
                                    bit want_hit = 1'b0, bit want_xfer = 1'b0,
                                    bit want_full = 1'b0);
    dir_row_t row;
    row.is_length = 1'b0;
    row.length = '0;
    row.ev.action = act;
    row.ev.cpu = cpu;
    row.ev.addr = addr;
    row.ev.io = io;
    row.typed = typed;
    row.want.interval_end = want_end;
    row.want.interval_count = want_count;
    row.want.interval_number = want_number;
    row.want.entry_hit = want_hit;
    row.want.transfer_seen = want_xfer;
    row.want.table_full = want_full;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_length(bit [LEN_W-1:0] v);
    dir_row_t row;
    row = '{is_length: 1'b1, length: v, ev: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, bit [CNT_W32-1:0] exp_v,
                                      logic [CNT_W32-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Offers one event, waits for the transaction and records its result.
  task automatic send_event(input share_ev_t ev, input bit typed, input share_res_t want);
    share_res_t predicted;
    while (!quiet && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= ev.action;
    in_ch.cpu       <= ev.cpu;
    in_ch.phys_addr <= ev.addr;
    in_ch.is_io     <= ev.io;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_sharing(ev);
    due_results.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  // Stops offering events and waits until every result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Writes the interval length while the block is idle.
  task automatic write_length(input bit [LEN_W-1:0] v);
    drain_results();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.retire_period <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    ilen = v;
    n_lengths++;
  endtask

  // Result side: random stalls, two long hold-offs, and the field checks.
  initial begin : result_sink
    share_res_t want;
    int         hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready) begin
          if (due_results.size() == 0) begin
            $error("result transaction with no event outstanding");
            errors++;
          end else begin
            want = due_results.pop_front();
            check_field("interval_end", want.interval_end, out_ch.interval_end);
            check_field("interval_count", want.interval_count, out_ch.interval_count);
            check_field("interval_number", want.interval_number, out_ch.interval_number);
            check_field("entry_hit", want.entry_hit, out_ch.entry_hit);
            check_field("transfer_seen", want.transfer_seen, out_ch.transfer_seen);
            check_field("table_full", want.table_full, out_ch.table_full);
            n_results++;
            n_intervals += want.interval_end;
            n_hits += want.entry_hit;
            n_xfers += want.transfer_seen;
            n_full += want.table_full;
            // Hold off long enough for the block to back up its input.
            if (n_results % 700 == 0) hold_left = 250;
          end
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= quiet || ($urandom_range(99) >= 36);
        end
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL core_to_core_sharing_monitor_top");
    $finish;
  end

  // Stimulus: directed table, then random phases.
  initial begin : stimulus
    share_ev_t ev;
    int        ph;
    int        k;
    int        pick;
    int        i;

    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_RETIRE;
    in_ch.cpu            = '0;
    in_ch.phys_addr      = '0;
    in_ch.is_io          = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.retire_period = '0;
    rst_n                = 1'b0;
    quiet                = 1'b0;

    // Predicted state after reset.
    foreach (blk_valid[i]) blk_valid[i] = 1'b0;
    blk_used      = 0;
    xfer_total    = '0;
    core0_retired = '0;
    interval_idx  = '0;
    ilen          = DEFAULT_INTERVAL;

    // Block 0 and the top block are the first two pool entries.
    address_pool[0] = '0;
    address_pool[1] = '1;
    for (i = 2; i < POOL_BLOCKS; i++) address_pool[i] = TAG_W'({$urandom, $urandom});

    // Directed rows. Typed results follow from the reset state at a glance.
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0, 1'b1);
    add_event(ACT_STORE, 2, 64'h0, 1'b0, 1'b1);
    add_event(ACT_STORE, 3, 64'h3F, 1'b0, 1'b1, 0, 0, 0, 1);
    add_event(ACT_LOAD, 1, 64'h10, 1'b0, 1'b1, 0, 0, 0, 1, 1);
    add_event(ACT_LOAD, 1, 64'h0, 1'b0, 1'b1, 0, 0, 0, 1);
    add_event(ACT_LOAD, 3, 64'h20, 1'b0, 1'b1, 0, 0, 0, 1);
    add_event(ACT_LOAD, 7, 64'h0, 1'b1, 1'b1);
    add_event(ACT_NONE, 0, 64'h0, 1'b0, 1'b1);
    add_event(ACT_LOAD, 4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    add_event(ACT_STORE, 7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    add_event(ACT_LOAD, 0, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 1'b1, 0, 0, 0, 1, 1);
    add_event(ACT_STORE, 0, 64'h40, 1'b1, 1'b1);
    add_event(ACT_LOAD, 5, 64'h7F, 1'b0, 1'b1);
    add_event(ACT_RETIRE, 6, 64'h0, 1'b0, 1'b1);
    // A zero length ends an interval on every core 0 retirement.
    add_length(31'd0);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0, 1'b1, 1, 2, 1);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0, 1'b1, 1, 0, 2);
    add_length(31'd1);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0, 1'b1, 1, 0, 3);
    add_length(31'd3);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0);
    add_event(ACT_LOAD, 2, 64'h8, 1'b0);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0);
    // Lowering the length below the running count closes the interval on the next core 0 retirement.
    add_length(31'd1);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0);
    add_length(31'h7FFF_FFFF);
    add_event(ACT_STORE, 5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_event(ACT_LOAD, 2, 64'h5555_5555_5555_5555, 1'b0);
    add_event(ACT_LOAD, 6, 64'hAAAA_AAAA_AAAA_AA80, 1'b0);
    add_event(ACT_RETIRE, 0, 64'h0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_length) begin
        write_length(directed_rows[i].length);
      end else begin
        send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random traffic; the block pool grows until the table overflows.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_length(ph == 6 ? LEN_W'($urandom_range(40, 1)) : phase_len[ph]);
      quiet = (ph == 2);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 3 && k == ITEMS_PER_PHASE / 2) drain_results();
        pick = $urandom_range(99);
        if (pick < 28) begin
          ev.action = ACT_RETIRE;
        end else if (pick < 60) begin
          ev.action = ACT_LOAD;
        end else if (pick < 94) begin
          ev.action = ACT_STORE;
        end else begin
          ev.action = ACT_NONE;
        end
        if (ev.action == ACT_RETIRE && $urandom_range(3) != 0) begin
          ev.cpu = '0;
        end else begin
          ev.cpu = CPU_W'($urandom_range(7));
        end
        ev.io = ($urandom_range(99) < 8);
        if ($urandom_range(99) < 5) begin
          ev.addr = {$urandom, $urandom};
        end else begin
          ev.addr = {address_pool[$urandom_range(pool_size[ph] - 1)],
                     BLOCK_SHIFT'($urandom)};
        end
        send_event(ev, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // Wait out the results, then a full table walk of quiet time.
    drain_results();
    repeat (2 * TABLE_ENTRIES + 20) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end

    $display("Run covered %0d events and %0d interval length writes in %0d cycles.",
             n_sent, n_lengths, cycle_count);
    $display("Results: %0d intervals closed, %0d block hits, %0d transfers, %0d dropped stores.",
             n_intervals, n_hits, n_xfers, n_full);
    if (errors == 0) begin
      $display("PASS core_to_core_sharing_monitor_top");
    end else begin
      $display("FAIL core_to_core_sharing_monitor_top");
    end
    $finish;
  end

endmodule
